// File: rtl/temperature_average_display_macros.svh
// Assertion helpers for the averaging display block
`ifndef TEMPERATURE_AVERAGE_DISPLAY_MACROS_SVH
`define TEMPERATURE_AVERAGE_DISPLAY_MACROS_SVH

// plain invariant, checked every clock out of reset
`define TAD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define TAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/tad_pkg.sv
package tad_pkg;

  localparam int ADC_W     = 10;
  localparam int REF_W     = 13;
  localparam int REF10_W   = 17;
  localparam int FPS_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;
  localparam int TEMP_W    = 14;
  localparam int SEG_W     = 8;
  localparam int DIG_W     = 4;
  localparam int POS_W     = 2;

  localparam int AVG_DEPTH_DEF = 8;

  localparam int TEMP_MAX   = 9999;
  localparam int ROUND_BIAS = 511;
  localparam int ADC_FULL   = 1023;

  // converted product: adc * vref * 10 + bias
  localparam int PROD_W     = 27;
  localparam int CONV_SHIFT = 27;
  localparam int CONV_RCP_W = 18;
  localparam int CONV_Q_W   = 17;
  localparam logic [CONV_RCP_W-1:0] CONV_RECIP = CONV_RCP_W'((2 ** CONV_SHIFT) / ADC_FULL);

  // decimal digit extraction
  localparam int DIG_SHIFT = 24;
  localparam int DIG_RCP_W = 25;

  localparam logic [SEG_W-1:0] DP_MASK = 8'h80;

  localparam logic [FPS_W-1:0] FPS_RESET   = 8'd250;
  localparam logic [REF10_W-1:0] REF10_RESET = 17'd50000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES = 1'b0,
    REG_VREF   = 1'b1
  } cfg_reg_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'h3F;
      4'd1: s = 8'h06;
      4'd2: s = 8'h5B;
      4'd3: s = 8'h4F;
      4'd4: s = 8'h66;
      4'd5: s = 8'h6D;
      4'd6: s = 8'h7D;
      4'd7: s = 8'h07;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  // ceil(2^DIG_SHIFT / 10^k); zero past the top digit
  function automatic logic [DIG_RCP_W-1:0] dig_recip(input logic [2:0] k);
    logic [DIG_RCP_W-1:0] m;
    case (k)
      3'd0: m = DIG_RCP_W'(2 ** DIG_SHIFT);
      3'd1: m = DIG_RCP_W'((2 ** DIG_SHIFT + 9) / 10);
      3'd2: m = DIG_RCP_W'((2 ** DIG_SHIFT + 99) / 100);
      3'd3: m = DIG_RCP_W'((2 ** DIG_SHIFT + 999) / 1000);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/temperature_average_display.sv
// A result passes through registered stages a to h and then the output register o.
// Throughput: one transaction per cycle while out_ready holds; a full stage stalls only when the stage after it stalls.
// The sample ring is a synchronous memory with a registered read, read one stage ahead of write.
// Reset (rst_n low, synchronous) clears counters, sum, average and valids, and returns config to its defaults;
// the ring is not cleared, seeding writes every entry before it is read.
`include "temperature_average_display_macros.svh"

module temperature_average_display #(
  parameter int AvgDepth = tad_pkg::AVG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tad_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tad_pkg::SEG_W-1:0]     out_segments,
  output logic [tad_pkg::DIG_W-1:0]     out_digit_enable,
  output logic [tad_pkg::TEMP_W-1:0]    out_average_centideg,
  output logic                          out_seeding,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tad_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int IdxW  = $clog2(AvgDepth);
  localparam int SeedW = $clog2(AvgDepth + 1);
  localparam int SumW  = $clog2(tad_pkg::TEMP_MAX * AvgDepth + 1);
  localparam logic [SumW-1:0] DepthS   = SumW'(AvgDepth);
  localparam logic [SumW-1:0] AvgRecip = SumW'((2 ** SumW) / AvgDepth);
  localparam logic [SumW-1:0] SumMax   = SumW'(tad_pkg::TEMP_MAX * AvgDepth);

  localparam int TW = tad_pkg::TEMP_W;
  localparam int PW = tad_pkg::PROD_W;
  localparam int QW = tad_pkg::CONV_Q_W;
  localparam int MW = TW + tad_pkg::DIG_RCP_W;

  typedef struct packed {
    logic                          store;
    logic                          sub;
    logic                          upd;
    logic                          seed;
    logic [tad_pkg::POS_W-1:0]     pos;
    logic [IdxW-1:0]               idx;
  } ctl_t;

  // config
  logic [tad_pkg::FPS_W-1:0]   fps_r;
  logic [tad_pkg::REF10_W-1:0] vref10_r;

  // sequencing state
  logic [SeedW-1:0]          seed_cnt_r;
  logic [tad_pkg::FPS_W-1:0] fc_r;
  logic [IdxW-1:0]           idx_r;
  logic [tad_pkg::POS_W-1:0] pos_r;
  logic [SumW-1:0]           sum_r;
  logic [TW-1:0]             avg_r;

  logic [TW-1:0] ring [AvgDepth];
  logic [TW-1:0] ring_rd_r;

  // stage valids
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r, o_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h, rdy_o;

  // stage payload
  ctl_t a_ctl_r, b_ctl_r, c_ctl_r, d_ctl_r, e_ctl_r, f_ctl_r, g_ctl_r, h_ctl_r;
  logic [PW-1:0]                          a_x_r, b_x_r, c_x_r;
  logic [PW+tad_pkg::CONV_RCP_W-1:0]      b_prod_r, c_prod_r;
  logic [TW-1:0]                          d_temp_r;
  logic [SumW-1:0]                        e_sum_r, f_sum_r;
  logic [2*SumW-1:0]                      f_prod_r;
  logic [TW-1:0]                          g_avg_r, h_avg_r;
  logic [MW-1:0]                          h_m1_r, h_m2_r;
  logic [tad_pkg::SEG_W-1:0]              o_seg_r;
  logic [tad_pkg::DIG_W-1:0]              o_en_r;
  logic [TW-1:0]                          o_avg_r;
  logic                                   o_seed_r;

  // accept-side decisions
  logic                      accept, seeding, last_seed, push;
  logic [tad_pkg::FPS_W-1:0] fc_inc;
  logic [IdxW-1:0]           idx_nxt;
  ctl_t                      in_ctl;
  logic [PW-1:0]             x_nxt;

  assign cfg_ready = 1'b1;

  assign rdy_o = !o_v_r || out_ready;
  assign rdy_h = !h_v_r || rdy_o;
  assign rdy_g = !g_v_r || rdy_h;
  assign rdy_f = !f_v_r || rdy_g;
  assign rdy_e = !e_v_r || rdy_f;
  assign rdy_d = !d_v_r || rdy_e;
  assign rdy_c = !c_v_r || rdy_d;
  assign rdy_b = !b_v_r || rdy_c;
  assign rdy_a = !a_v_r || rdy_b;
  assign in_ready = rdy_a;
  assign accept   = in_valid && in_ready;

  assign seeding   = seed_cnt_r < SeedW'(AvgDepth);
  assign last_seed = seed_cnt_r == SeedW'(AvgDepth - 1);
  assign fc_inc    = fc_r + 1'b1;
  assign push      = !seeding && (fc_inc >= fps_r);
  assign idx_nxt   = (idx_r == IdxW'(AvgDepth - 1)) ? '0 : idx_r + 1'b1;

  always_comb begin
    in_ctl.store = seeding || push;
    in_ctl.sub   = push;
    in_ctl.upd   = last_seed || push;
    in_ctl.seed  = seeding;
    in_ctl.pos   = pos_r;
    in_ctl.idx   = idx_r;
  end

  assign x_nxt = PW'(in_adc_sample) * PW'(vref10_r) + PW'(tad_pkg::ROUND_BIAS);

  // stage c: finish /1023 with one correction, then clamp
  logic [QW-1:0] c_q0, c_q;
  logic [PW-1:0] c_rem;
  logic [TW-1:0] c_temp;
  always_comb begin
    c_q0  = c_prod_r[tad_pkg::CONV_SHIFT +: QW];
    c_rem = c_x_r - {c_q0, 10'b0} + PW'(c_q0);
    c_q   = (c_rem >= PW'(tad_pkg::ADC_FULL)) ? c_q0 + 1'b1 : c_q0;
    c_temp = (c_q > QW'(tad_pkg::TEMP_MAX)) ? TW'(tad_pkg::TEMP_MAX) : c_q[TW-1:0];
  end

  // stage d: running sum update
  logic            ring_we, ring_re;
  logic [SumW-1:0] sum_nxt;
  assign ring_re = c_v_r && rdy_d && c_ctl_r.sub;
  assign ring_we = d_v_r && rdy_e && d_ctl_r.store;
  assign sum_nxt = sum_r - (d_ctl_r.sub ? SumW'(ring_rd_r) : '0) + SumW'(d_temp_r);

  // stage f: finish /AvgDepth with one correction
  logic [SumW-1:0] f_q0, f_rem, f_q;
  logic [TW-1:0]   avg_new;
  always_comb begin
    f_q0    = f_prod_r[SumW +: SumW];
    f_rem   = f_sum_r - f_q0 * DepthS;
    f_q     = (f_rem >= DepthS) ? f_q0 + 1'b1 : f_q0;
    avg_new = f_q[TW-1:0];
  end

  // stage h: digit select and segment encode
  logic [TW-1:0]             h_q, h_q10;
  logic [3:0]                h_tens, h_dig;
  logic [tad_pkg::SEG_W-1:0] h_seg;
  logic [tad_pkg::DIG_W-1:0] h_en;
  always_comb begin
    h_q    = h_m1_r[tad_pkg::DIG_SHIFT +: TW];
    h_q10  = h_m2_r[tad_pkg::DIG_SHIFT +: TW];
    h_tens = {h_q10[0], 3'b000} + {h_q10[2:0], 1'b0};
    h_dig  = h_q[3:0] - h_tens;
    h_seg  = tad_pkg::seg_code(h_dig);
    h_en   = tad_pkg::DIG_W'(1) << h_ctl_r.pos;
    case (h_ctl_r.pos)
      2'd1: h_seg = h_seg | tad_pkg::DP_MASK;
      2'd3: if (h_dig == 4'd0) h_seg = '0;
      default: ;
    endcase
    if (h_ctl_r.seed) begin
      h_seg = '0;
      h_en  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fps_r      <= tad_pkg::FPS_RESET;
      vref10_r   <= tad_pkg::REF10_RESET;
      seed_cnt_r <= '0;
      fc_r       <= '0;
      idx_r      <= '0;
      pos_r      <= '0;
      sum_r      <= '0;
      avg_r      <= '0;
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0;
      d_v_r <= 1'b0; e_v_r <= 1'b0; f_v_r <= 1'b0;
      g_v_r <= 1'b0; h_v_r <= 1'b0; o_v_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tad_pkg::REG_FRAMES: fps_r <= cfg_data[tad_pkg::FPS_W-1:0];
          tad_pkg::REG_VREF:   vref10_r <= tad_pkg::REF10_W'(cfg_data) * tad_pkg::REF10_W'(10);
          default: ;
        endcase
      end
      if (accept) begin
        if (seeding) begin
          seed_cnt_r <= seed_cnt_r + 1'b1;
        end else begin
          fc_r  <= push ? '0 : fc_inc;
          pos_r <= pos_r + 1'b1;
        end
        if (in_ctl.store) idx_r <= idx_nxt;
      end
      if (ring_we) sum_r <= sum_nxt;
      if (f_v_r && rdy_g && f_ctl_r.upd) avg_r <= avg_new;
      if (rdy_a) a_v_r <= in_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
      if (rdy_e) e_v_r <= d_v_r;
      if (rdy_f) f_v_r <= e_v_r;
      if (rdy_g) g_v_r <= f_v_r;
      if (rdy_h) h_v_r <= g_v_r;
      if (rdy_o) o_v_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring[d_ctl_r.idx] <= d_temp_r;
  end

  always_ff @(posedge clk) begin
    if (ring_re) ring_rd_r <= ring[c_ctl_r.idx];
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_ctl_r <= in_ctl;
      a_x_r   <= x_nxt;
    end
    if (rdy_b) begin
      b_ctl_r  <= a_ctl_r;
      b_x_r    <= a_x_r;
      b_prod_r <= a_x_r * tad_pkg::CONV_RECIP;
    end
    if (rdy_c) begin
      c_ctl_r  <= b_ctl_r;
      c_x_r    <= b_x_r;
      c_prod_r <= b_prod_r;
    end
    if (rdy_d) begin
      d_ctl_r  <= c_ctl_r;
      d_temp_r <= c_temp;
    end
    if (rdy_e) begin
      e_ctl_r <= d_ctl_r;
      e_sum_r <= sum_nxt;
    end
    if (rdy_f) begin
      f_ctl_r  <= e_ctl_r;
      f_sum_r  <= e_sum_r;
      f_prod_r <= e_sum_r * AvgRecip;
    end
    if (rdy_g) begin
      g_ctl_r <= f_ctl_r;
      g_avg_r <= f_ctl_r.upd ? avg_new : avg_r;
    end
    if (rdy_h) begin
      h_ctl_r <= g_ctl_r;
      h_avg_r <= g_avg_r;
      h_m1_r  <= g_avg_r * tad_pkg::dig_recip({1'b0, g_ctl_r.pos});
      h_m2_r  <= g_avg_r * tad_pkg::dig_recip({1'b0, g_ctl_r.pos} + 3'd1);
    end
    if (rdy_o) begin
      o_seg_r  <= h_seg;
      o_en_r   <= h_en;
      o_avg_r  <= h_avg_r;
      o_seed_r <= h_ctl_r.seed;
    end
  end

  assign out_valid            = o_v_r;
  assign out_segments         = o_seg_r;
  assign out_digit_enable     = o_en_r;
  assign out_average_centideg = o_avg_r;
  assign out_seeding          = o_seed_r;

  `TAD_ASSERT_IMP(a_ring_no_collide, ring_we && ring_re, d_ctl_r.idx != c_ctl_r.idx, "clash")
  `TAD_ASSERT_IMP(a_digit_onehot, out_valid && !out_seeding, $onehot(out_digit_enable), "onehot")
  `TAD_ASSERT(a_sum_bound, sum_r <= SumMax, "running sum above full scale")
  `TAD_ASSERT_IMP(a_avg_bound, out_valid, out_average_centideg <= TW'(tad_pkg::TEMP_MAX), "range")

endmodule
